FILE: src/dqmc_pkg.sv
// Shared types, codes and defaults for the deque with membership count.
package dqmc_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int VALUE_BITS_DEF = 12;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 12;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 9;

    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SIZE       = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   size;
        logic                found;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_UPD,
        S_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic take;
        logic rd_old;
        logic occ_wr;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic pop_go;
        logic occ_go;
        logic out_free;
    } stat_t;

endpackage

FILE: src/dqmc_ctrl.sv
// Sequencing state machine of the deque with membership count.
module dqmc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dqmc_pkg::stat_t stat,
    output dqmc_pkg::cmd_t  cmd
);

    dqmc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dqmc_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dqmc_pkg::S_CLEAR: begin
                if (stat.clr_done) state_next = dqmc_pkg::S_IDLE;
            end
            dqmc_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (stat.pop_go)      state_next = dqmc_pkg::S_LOOK;
                    else if (stat.occ_go) state_next = dqmc_pkg::S_UPD;
                    else                  state_next = dqmc_pkg::S_FIN;
                end
            end
            dqmc_pkg::S_LOOK: state_next = dqmc_pkg::S_UPD;
            dqmc_pkg::S_UPD: begin
                state_next = stat.out_free ? dqmc_pkg::S_IDLE : dqmc_pkg::S_FIN;
            end
            dqmc_pkg::S_FIN: begin
                if (stat.out_free) state_next = dqmc_pkg::S_IDLE;
            end
            default: state_next = dqmc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            dqmc_pkg::S_CLEAR: cmd.clr_step = 1'b1;
            dqmc_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            dqmc_pkg::S_LOOK: cmd.rd_old = 1'b1;
            dqmc_pkg::S_UPD: begin
                cmd.occ_wr   = 1'b1;
                cmd.load_out = stat.out_free;
            end
            dqmc_pkg::S_FIN: cmd.load_out = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

FILE: src/dqmc_datapath.sv
// Ring storage, pointers, occurrence table and result register.
module dqmc_datapath #(
    parameter int DEPTH      = dqmc_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = dqmc_pkg::VALUE_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  dqmc_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dqmc_pkg::rsp_t  m_data,
    input  dqmc_pkg::cmd_t  cmd,
    output dqmc_pkg::stat_t stat
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int SPAN = 1 << VALUE_BITS;

    function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] pos);
        logic [SW-1:0] r;
        r = (pos >= SW'(DEPTH)) ? pos - SW'(DEPTH) : pos;
        return r[AW-1:0];
    endfunction

    logic [AW-1:0]              head_reg, head_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [VALUE_BITS-1:0]      clr_idx_reg, clr_idx_next;
    logic                       m_valid_reg, m_valid_next;
    logic [dqmc_pkg::OPCODE_W-1:0] op_reg;
    logic [dqmc_pkg::STATUS_W-1:0] status_reg, status_next;
    dqmc_pkg::rsp_t             rsp_reg;

    logic [VALUE_BITS-1:0]      in_val;
    logic [dqmc_pkg::SIZE_W-1:0] size_val;
    logic                       full, empty, push_in, pop_in;
    logic [SW-1:0]              back_sum, last_sum;
    logic [AW-1:0]              head_dec, head_inc, pos;
    logic                       st_we, st_re;

    logic [VALUE_BITS-1:0]      store_mem [DEPTH];
    logic [VALUE_BITS-1:0]      store_rd_reg;

    logic [CW-1:0]              occ_mem [SPAN];
    logic [CW-1:0]              occ_rd_reg;
    logic [VALUE_BITS-1:0]      occ_addr_reg;
    logic [VALUE_BITS-1:0]      occ_raddr, occ_waddr;
    logic [CW-1:0]              occ_wdata;
    logic                       occ_re, occ_we, op_push, op_pop;

    if (VALUE_BITS <= dqmc_pkg::VALUE_W) begin : g_val_narrow
        assign in_val = s_data.value[VALUE_BITS-1:0];
    end else begin : g_val_wide
        assign in_val = {{(VALUE_BITS - dqmc_pkg::VALUE_W){1'b0}}, s_data.value};
    end

    if (CW >= dqmc_pkg::SIZE_W) begin : g_size_trunc
        assign size_val = count_reg[dqmc_pkg::SIZE_W-1:0];
    end else begin : g_size_ext
        assign size_val = {{(dqmc_pkg::SIZE_W - CW){1'b0}}, count_reg};
    end

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_in = (s_data.opcode == dqmc_pkg::OP_PUSH_BACK) ||
                     (s_data.opcode == dqmc_pkg::OP_PUSH_FRONT);
    assign pop_in  = (s_data.opcode == dqmc_pkg::OP_POP_BACK) ||
                     (s_data.opcode == dqmc_pkg::OP_POP_FRONT);

    assign back_sum = SW'(head_reg) + SW'(count_reg);
    assign last_sum = back_sum - SW'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // Pointer update and ring access, all at the moment a request is taken.
    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pos         = '0;
        st_we       = 1'b0;
        st_re       = 1'b0;
        if (cmd.take) begin
            status_next = dqmc_pkg::ST_OK;
            case (s_data.opcode)
                dqmc_pkg::OP_PUSH_BACK: begin
                    if (full) begin
                        status_next = dqmc_pkg::ST_FULL;
                    end else begin
                        pos        = ring_wrap(back_sum);
                        st_we      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                dqmc_pkg::OP_PUSH_FRONT: begin
                    if (full) begin
                        status_next = dqmc_pkg::ST_FULL;
                    end else begin
                        head_next  = head_dec;
                        pos        = head_dec;
                        st_we      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                dqmc_pkg::OP_POP_BACK: begin
                    if (empty) begin
                        status_next = dqmc_pkg::ST_EMPTY;
                    end else begin
                        pos        = ring_wrap(last_sum);
                        st_re      = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                dqmc_pkg::OP_POP_FRONT: begin
                    if (empty) begin
                        status_next = dqmc_pkg::ST_EMPTY;
                    end else begin
                        pos        = head_reg;
                        head_next  = head_inc;
                        st_re      = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                default: status_next = dqmc_pkg::ST_OK;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) store_mem[pos] <= in_val;
        if (st_re) store_rd_reg <= store_mem[pos];
    end

    // Occurrence table: one read port, one write port, read data registered.
    assign op_push   = (op_reg == dqmc_pkg::OP_PUSH_BACK) ||
                       (op_reg == dqmc_pkg::OP_PUSH_FRONT);
    assign op_pop    = (op_reg == dqmc_pkg::OP_POP_BACK) ||
                       (op_reg == dqmc_pkg::OP_POP_FRONT);
    assign occ_re    = cmd.take || cmd.rd_old;
    assign occ_raddr = cmd.take ? in_val : store_rd_reg;
    assign occ_we    = cmd.clr_step || (cmd.occ_wr && (op_push || op_pop));
    assign occ_waddr = cmd.clr_step ? clr_idx_reg : occ_addr_reg;

    always_comb begin
        occ_wdata = occ_rd_reg;
        if (cmd.clr_step)                occ_wdata = '0;
        else if (op_push)                occ_wdata = occ_rd_reg + CW'(1);
        else if (occ_rd_reg != '0)       occ_wdata = occ_rd_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
        if (occ_re) begin
            occ_rd_reg   <= occ_mem[occ_raddr];
            occ_addr_reg <= occ_raddr;
        end
    end

    assign clr_idx_next = cmd.clr_step ? clr_idx_reg + VALUE_BITS'(1) : clr_idx_reg;
    assign m_valid_next = cmd.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (cmd.take) op_reg <= s_data.opcode;
        if (cmd.load_out) begin
            rsp_reg.status <= status_reg;
            rsp_reg.size   <= size_val;
            rsp_reg.found  <= (op_reg == dqmc_pkg::OP_SEARCH) && (occ_rd_reg != '0);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

    assign stat.clr_done = (clr_idx_reg == '1);
    assign stat.pop_go   = pop_in && !empty;
    assign stat.occ_go   = (push_in && !full) || (s_data.opcode == dqmc_pkg::OP_SEARCH);
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule

FILE: src/deque_with_membership_count.sv
// Top level of the deque with membership count.
//
// A request on the s_ channel carries an opcode and a value: push back, push
// front, pop back, pop front, size, or search. Every request yields exactly one
// response on the m_ channel with a status (ok, empty on pop, full on push),
// the number of entries after the request, and for a search whether the value
// is currently held in the queue.
// Entries live in a ring buffer of DEPTH words; a second memory keeps, for each
// of the 2**VALUE_BITS values, how many copies are in the queue.
// One request is worked on at a time; the next is not taken before the
// response to the last is loaded. Push and search requests go through the
// update step, size and refused requests through the finish step, and a
// successful pop takes an extra step: it must first read the ring entry and
// then read-modify-write its occurrence count through the table's single
// registered read port. The next request is taken the cycle after the
// response is loaded. After reset the occurrence table is swept to zero,
// one entry per cycle; s_ready stays low until then.
// If the receiver holds m_ready low, the response waits in its output
// register; the block still takes one further request and keeps its result
// until the output register frees up.
module deque_with_membership_count #(
    parameter int DEPTH      = dqmc_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = dqmc_pkg::VALUE_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dqmc_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output dqmc_pkg::rsp_t m_data
);

    dqmc_pkg::cmd_t  cmd;
    dqmc_pkg::stat_t stat;

    // Controller: decides the step sequence for each request.
    dqmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: ring memory, occurrence table and response register.
    dqmc_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

FILE: src/dqmc_checker.sv
// Port-level checks for the deque with membership count, bound to the top.
module dqmc_checker #(
    parameter int DEPTH = dqmc_pkg::DEPTH_DEF
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input dqmc_pkg::req_t s_data,
    input logic           m_valid,
    input logic           m_ready,
    input dqmc_pkg::rsp_t m_data
);

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("response changed while stalled");

    // The table sweep keeps requests out right after reset.
    a_reset_block: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request port open right after reset");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken back to back");

    // An empty pop reports an empty queue and no match.
    a_empty_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == dqmc_pkg::ST_EMPTY)
            |-> (m_data.size == '0) && !m_data.found)
        else $error("empty status with nonzero size");

    // A refused push reports a full queue; a match is always an ok response.
    a_full_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.status != dqmc_pkg::ST_FULL) ||
                     (m_data.size == dqmc_pkg::SIZE_W'(DEPTH))) &&
                    (!m_data.found || (m_data.status == dqmc_pkg::ST_OK)))
        else $error("full status or found flag inconsistent");

endmodule

bind deque_with_membership_count dqmc_checker #(.DEPTH(DEPTH)) u_dqmc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: test/deque_with_membership_count_test.sv
// Self-checking testbench for the deque with membership count.
`timescale 1ns / 1ps

module deque_with_membership_count_test;

    localparam int DEPTH      = dqmc_pkg::DEPTH_DEF;
    localparam int VALUE_SPAN = 1 << dqmc_pkg::VALUE_BITS_DEF;

    // Opcodes the block does not define; they must leave the state alone.
    localparam logic [dqmc_pkg::OPCODE_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [dqmc_pkg::OPCODE_W-1:0] OP_SPARE_B = 3'd7;

    // Cycles without any handshake before the run is declared hung. The limit
    // must also cover the sweep of the occurrence table after reset.
    localparam int STALL_LIMIT = 5 * VALUE_SPAN;
    // Once this few requests are left, both sides stop idling.
    localparam int QUIET_TAIL  = 200;
    localparam int TOTAL_REQS  = 1900;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    dqmc_pkg::req_t s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    dqmc_pkg::rsp_t m_data;

    always #6 aclk = ~aclk;

    deque_with_membership_count u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Requests waiting to be driven, and responses the deque owes us.
    dqmc_pkg::req_t cmd_backlog[$];
    dqmc_pkg::rsp_t due_responses[$];
    int             error_count = 0;

    // Our own copy of the deque: ring storage, front position, fill level and
    // the number of copies of each value that are currently queued.
    logic [dqmc_pkg::VALUE_W-1:0] ring_mem[DEPTH];
    int                           front_idx = 0;
    int                           fill_cnt  = 0;
    int                           copy_cnt[VALUE_SPAN];

    // Fill level as seen while the request list is built, used only to steer
    // the random mix toward full and empty.
    int gen_fill = 0;

    initial begin
        foreach (copy_cnt[i]) copy_cnt[i] = 0;
        foreach (ring_mem[i]) ring_mem[i] = '0;
    end

    // Applies one request to the copy of the deque and returns the response
    // that the block has to produce for it.
    function automatic dqmc_pkg::rsp_t apply_command(dqmc_pkg::req_t cmd);
        dqmc_pkg::rsp_t rsp;
        int             pos;
        rsp        = '0;
        rsp.status = dqmc_pkg::ST_OK;
        case (cmd.opcode)
            dqmc_pkg::OP_PUSH_BACK, dqmc_pkg::OP_PUSH_FRONT: begin
                if (fill_cnt >= DEPTH) begin
                    rsp.status = dqmc_pkg::ST_FULL;
                end else begin
                    if (cmd.opcode == dqmc_pkg::OP_PUSH_BACK) begin
                        pos = (front_idx + fill_cnt) % DEPTH;
                    end else begin
                        front_idx = (front_idx + DEPTH - 1) % DEPTH;
                        pos       = front_idx;
                    end
                    ring_mem[pos] = cmd.value;
                    fill_cnt++;
                    copy_cnt[cmd.value]++;
                end
            end
            dqmc_pkg::OP_POP_BACK, dqmc_pkg::OP_POP_FRONT: begin
                if (fill_cnt == 0) begin
                    rsp.status = dqmc_pkg::ST_EMPTY;
                end else begin
                    if (cmd.opcode == dqmc_pkg::OP_POP_BACK) begin
                        pos = (front_idx + fill_cnt - 1) % DEPTH;
                    end else begin
                        pos       = front_idx;
                        front_idx = (front_idx + 1) % DEPTH;
                    end
                    if (copy_cnt[ring_mem[pos]] != 0) copy_cnt[ring_mem[pos]]--;
                    fill_cnt--;
                end
            end
            dqmc_pkg::OP_SEARCH: begin
                rsp.found = (copy_cnt[cmd.value] != 0);
            end
            default: begin
            end
        endcase
        rsp.size = dqmc_pkg::SIZE_W'(fill_cnt);
        return rsp;
    endfunction

    // Queues one request and tracks the fill level it leads to.
    function automatic void add_request(logic [dqmc_pkg::OPCODE_W-1:0] op,
                                        logic [dqmc_pkg::VALUE_W-1:0] val);
        dqmc_pkg::req_t r;
        r.opcode = op;
        r.value  = val;
        cmd_backlog.push_back(r);
        if ((op == dqmc_pkg::OP_PUSH_BACK || op == dqmc_pkg::OP_PUSH_FRONT) &&
            gen_fill < DEPTH) gen_fill++;
        if ((op == dqmc_pkg::OP_POP_BACK || op == dqmc_pkg::OP_POP_FRONT) &&
            gen_fill > 0) gen_fill--;
    endfunction

    // Values come mostly from narrow pools at both ends of the range so that
    // duplicates pile up and searches hit; the rest spread over the whole range.
    function automatic logic [dqmc_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0, 1:    return dqmc_pkg::VALUE_W'($urandom_range(0, 15));
            2:       return dqmc_pkg::VALUE_W'(VALUE_SPAN - 1 - $urandom_range(0, 15));
            default: return dqmc_pkg::VALUE_W'($urandom_range(0, VALUE_SPAN - 1));
        endcase
    endfunction

    function automatic void add_random_request(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            add_request($urandom_range(0, 1) ? dqmc_pkg::OP_PUSH_FRONT : dqmc_pkg::OP_PUSH_BACK,
                        pick_value());
        else if (roll < push_pct + pop_pct)
            add_request($urandom_range(0, 1) ? dqmc_pkg::OP_POP_FRONT : dqmc_pkg::OP_POP_BACK,
                        dqmc_pkg::VALUE_W'($urandom_range(0, VALUE_SPAN - 1)));
        else if (roll < 94)
            add_request(dqmc_pkg::OP_SEARCH, pick_value());
        else if (roll < 97)
            add_request(dqmc_pkg::OP_SIZE,
                        dqmc_pkg::VALUE_W'($urandom_range(0, VALUE_SPAN - 1)));
        else
            add_request($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                        dqmc_pkg::VALUE_W'($urandom_range(0, VALUE_SPAN - 1)));
    endfunction

    // Driver. A request is taken at an edge where s_valid and s_ready were both
    // high; at that same edge its response is predicted. A new request is put
    // up right away unless an idle burst is running. Bursts are switched on
    // and off in stretches and stop entirely near the end of the run.
    int   src_gap     = 0;
    logic src_bursty  = 1'b1;
    logic nxt_s_valid;
    logic s_fire;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            s_fire = s_valid && s_ready;
            if (s_fire) begin
                due_responses.push_back(apply_command(s_data));
                if ($urandom_range(0, 63) == 0) src_bursty = !src_bursty;
                if (src_bursty && cmd_backlog.size() > QUIET_TAIL &&
                    $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 10);
            end
            if (s_valid && !s_fire) begin
                // Hold the request until it is taken.
                nxt_s_valid = 1'b1;
            end else if (src_gap > 0) begin
                src_gap--;
                nxt_s_valid = 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                s_data <= cmd_backlog.pop_front();
                nxt_s_valid = 1'b1;
            end else begin
                nxt_s_valid = 1'b0;
            end
            s_valid <= nxt_s_valid;
        end
    end

    // Monitor. Each response taken is compared field by field with the oldest
    // prediction. m_ready drops in random bursts, likewise switched on and
    // off in stretches and quiet near the end.
    int             sink_gap    = 0;
    logic           sink_bursty = 1'b1;
    dqmc_pkg::rsp_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_responses.size() == 0) begin
                    $display("%0t: response with no request outstanding: status %0d size %0d found %0d",
                             $time, m_data.status, m_data.size, m_data.found);
                    error_count++;
                end else begin
                    want = due_responses.pop_front();
                    if (m_data.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_data.status);
                        error_count++;
                    end
                    if (m_data.size !== want.size) begin
                        $display("%0t: size mismatch, expected %0d, actual %0d",
                                 $time, want.size, m_data.size);
                        error_count++;
                    end
                    if (m_data.found !== want.found) begin
                        $display("%0t: found mismatch, expected %0d, actual %0d",
                                 $time, want.found, m_data.found);
                        error_count++;
                    end
                end
                if ($urandom_range(0, 63) == 0) sink_bursty = !sink_bursty;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (sink_bursty && cmd_backlog.size() > QUIET_TAIL &&
                         $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 10) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: the run is hung if no handshake happens on either side for
    // too long. The counter only runs once reset has been released.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase_len;
        int mode;

        // Directed part: pops and a size on the empty deque, the unused
        // opcodes, both value extremes pushed (the top one at both ends), searches that hit
        // and miss, and a duplicate value that stays found after one copy is
        // popped.
        add_request(dqmc_pkg::OP_POP_BACK, '0);
        add_request(dqmc_pkg::OP_POP_FRONT, '1);
        add_request(dqmc_pkg::OP_SIZE, '0);
        add_request(dqmc_pkg::OP_SEARCH, '0);
        add_request(OP_SPARE_A, '0);
        add_request(OP_SPARE_B, '1);
        add_request(dqmc_pkg::OP_PUSH_BACK, '0);
        add_request(dqmc_pkg::OP_PUSH_FRONT, '1);
        add_request(dqmc_pkg::OP_PUSH_BACK, '1);
        add_request(dqmc_pkg::OP_SEARCH, '1);
        add_request(dqmc_pkg::OP_SEARCH, '0);
        add_request(dqmc_pkg::OP_SEARCH, dqmc_pkg::VALUE_W'(1));
        add_request(OP_SPARE_B, dqmc_pkg::VALUE_W'(1));
        add_request(dqmc_pkg::OP_POP_FRONT, '0);
        add_request(dqmc_pkg::OP_SEARCH, '1);
        add_request(dqmc_pkg::OP_POP_FRONT, '0);
        add_request(dqmc_pkg::OP_SEARCH, '0);
        add_request(dqmc_pkg::OP_POP_BACK, '0);
        add_request(dqmc_pkg::OP_SEARCH, '1);
        add_request(dqmc_pkg::OP_POP_FRONT, '0);
        add_request(dqmc_pkg::OP_SIZE, '1);

        // Fill the deque to the brim from both ends, push into the full deque
        // at both ends, then drain it past empty.
        while (gen_fill < DEPTH)
            add_request($urandom_range(0, 1) ? dqmc_pkg::OP_PUSH_FRONT : dqmc_pkg::OP_PUSH_BACK,
                        pick_value());
        add_request(dqmc_pkg::OP_PUSH_BACK, pick_value());
        add_request(dqmc_pkg::OP_PUSH_FRONT, pick_value());
        add_request(dqmc_pkg::OP_SEARCH, pick_value());
        add_request(dqmc_pkg::OP_SIZE, '0);
        while (gen_fill > 0)
            add_request($urandom_range(0, 1) ? dqmc_pkg::OP_POP_FRONT : dqmc_pkg::OP_POP_BACK,
                        pick_value());
        add_request(dqmc_pkg::OP_POP_FRONT, '0);

        // Random part in phases that lean toward growing, shrinking or
        // holding the level, so the ring wraps and both bounds recur.
        while (cmd_backlog.size() < TOTAL_REQS) begin
            mode      = $urandom_range(0, 2);
            phase_len = $urandom_range(40, 300);
            repeat (phase_len) begin
                case (mode)
                    0:       add_random_request(70, 15);
                    1:       add_random_request(15, 70);
                    default: add_random_request(40, 40);
                endcase
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_backlog.size() != 0 || s_valid) @(posedge aclk);
        while (due_responses.size() != 0) @(posedge aclk);
        // A few more cycles so a stray extra response would still be seen.
        repeat (10) @(posedge aclk);

        if (error_count == 0 && due_responses.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
